// File: rtl/preemptive_priority_scheduler_unit_macros.svh
// Assertion macros shared by the scheduler modules.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PPS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pps_pkg.sv
// Types and constants shared by the scheduler controller, datapath and top level.
package pps_pkg;

  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int COUNT_W   = $clog2(MAX_TASKS + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [15:0]        burst_length;
    logic [31:0]        arrival;
    logic signed [15:0] task_priority;
  } in_t;

  typedef struct packed {
    logic [31:0]       tick_time;
    logic              idle;
    logic [SLOT_W-1:0] task_slot;
    logic              table_full;
    logic              finished;
    logic [31:0]       turnaround;
    logic [31:0]       waiting;
    logic [31:0]       response;
    logic              all_done;
  } out_t;

  typedef struct packed {
    logic [15:0]        burst;
    logic [15:0]        remaining;
    logic [31:0]        arrival;
    logic signed [15:0] task_priority;
    logic [31:0]        first_start;
  } entry_t;

  typedef struct packed {
    logic              capture;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_idx;
    logic              commit_load;
    logic              commit_tick;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/pps_ctrl.sv
// Controller state machine that sequences loads, the slot scan and the tick update.
`include "preemptive_priority_scheduler_unit_macros.svh"

module pps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                op,
  input  pps_pkg::dp_status_t status,
  output logic                req_stall,
  output pps_pkg::dp_cmd_t    cmd
);
  import pps_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_TICK  = 3'd4;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(MAX_TASKS - 1);

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [SLOT_W-1:0] scan_idx;
  logic [SLOT_W-1:0] scan_idx_next;

  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    cmd           = '0;
    req_stall     = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture   = 1'b1;
          scan_idx_next = '0;
          state_next    = (op == OP_LOAD) ? ST_LOAD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_idx = scan_idx;
        if (scan_idx == LAST_IDX) begin
          state_next = ST_DRAIN;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_next = ST_TICK;
      end
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.commit_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (status.out_free) begin
          cmd.commit_tick = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_idx <= '0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
    end
  end

  `PPS_ASSERT_NEXT(a_scan_ends, state == ST_SCAN && scan_idx == LAST_IDX, state == ST_DRAIN, "scan did not end after the last slot")
  `PPS_ASSERT_IMPLIES(a_commit_free, cmd.commit_load || cmd.commit_tick, status.out_free, "commit while the result register is blocked")
  `PPS_ASSERT_NEXT(a_commit_idle, cmd.commit_load || cmd.commit_tick, state == ST_IDLE, "controller did not return to idle after a commit")

endmodule

// File: rtl/pps_dp.sv
// Datapath with the task table, the winner search registers, the counters and the result register.
`include "preemptive_priority_scheduler_unit_macros.svh"

module pps_dp (
  input  logic                clk,
  input  logic                rst,
  input  pps_pkg::in_t        req,
  input  pps_pkg::dp_cmd_t    cmd,
  output pps_pkg::dp_status_t status,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output pps_pkg::out_t       rsp
);
  import pps_pkg::*;

  in_t                item;
  logic [31:0]        clock_now;
  logic [31:0]        clock_now_next;
  logic [COUNT_W-1:0] task_count;
  logic [COUNT_W-1:0] task_count_next;
  logic [COUNT_W-1:0] done_count;
  logic [COUNT_W-1:0] done_count_next;
  logic [MAX_TASKS-1:0] fin_flags;

  entry_t             mem [MAX_TASKS];
  entry_t             rdata;
  logic               cmp_valid;
  logic [SLOT_W-1:0]  cmp_idx;
  logic               have;
  logic [SLOT_W-1:0]  best_idx;
  entry_t             best;

  logic               cand_ready;
  logic               cand_better;
  logic               table_full;
  logic [SLOT_W-1:0]  load_slot;
  logic               zero_burst;
  logic [15:0]        rem_new;
  logic [31:0]        fs_new;
  logic [31:0]        tat;
  logic               tick_done;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  entry_t             wr_data;
  out_t               res;

  assign status.out_free = !rsp_valid || !rsp_stall;

  assign cand_ready = cmp_valid && !fin_flags[cmp_idx] && (rdata.arrival <= clock_now);
  assign cand_better = !have ||
                       ($signed(rdata.task_priority) > $signed(best.task_priority)) ||
                       ((rdata.task_priority == best.task_priority) &&
                        (rdata.arrival < best.arrival));

  assign table_full = (task_count >= COUNT_W'(MAX_TASKS));
  assign load_slot  = task_count[SLOT_W-1:0];
  assign zero_burst = (item.burst_length == 16'd0);

  assign rem_new   = best.remaining - 16'd1;
  assign fs_new    = (best.remaining == best.burst) ? clock_now : best.first_start;
  assign tat       = (clock_now + 32'd1) - best.arrival;
  assign tick_done = have && (rem_new == 16'd0);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_idx;
    wr_data = best;
    if (cmd.commit_load && !table_full) begin
      wr_en                 = 1'b1;
      wr_addr               = load_slot;
      wr_data.burst         = item.burst_length;
      wr_data.remaining     = item.burst_length;
      wr_data.arrival       = item.arrival;
      wr_data.task_priority = item.task_priority;
      wr_data.first_start   = '0;
    end else if (cmd.commit_tick && have) begin
      wr_en               = 1'b1;
      wr_data.remaining   = rem_new;
      wr_data.first_start = fs_new;
    end
  end

  always_comb begin
    task_count_next = task_count;
    done_count_next = done_count;
    clock_now_next  = clock_now;
    res             = '0;
    res.tick_time   = clock_now;
    if (cmd.commit_load) begin
      if (table_full) begin
        res.table_full = 1'b1;
      end else begin
        task_count_next = task_count + 1'b1;
        res.task_slot   = load_slot;
        if (zero_burst) begin
          done_count_next = done_count + 1'b1;
        end
      end
    end
    if (cmd.commit_tick) begin
      clock_now_next = clock_now + 32'd1;
      if (!have) begin
        res.idle = 1'b1;
      end else begin
        res.task_slot = best_idx;
        if (tick_done) begin
          done_count_next = done_count + 1'b1;
          res.finished    = 1'b1;
          res.turnaround  = tat;
          res.waiting     = tat - {16'd0, best.burst};
          res.response    = fs_new - best.arrival;
        end
      end
    end
    res.all_done = (done_count_next == task_count_next);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[cmd.rd_idx];
    end
    cmp_idx <= cmd.rd_idx;
    if (cmd.capture) begin
      item <= req;
    end
    if (cand_ready && cand_better) begin
      best_idx <= cmp_idx;
      best     <= rdata;
    end
    if (cmd.commit_load || cmd.commit_tick) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_now  <= '0;
      task_count <= '0;
      done_count <= '0;
      fin_flags  <= '0;
      cmp_valid  <= 1'b0;
      have       <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      clock_now  <= clock_now_next;
      task_count <= task_count_next;
      done_count <= done_count_next;
      cmp_valid  <= cmd.rd_en && ({1'b0, cmd.rd_idx} < task_count);
      if (cmd.commit_load && !table_full) begin
        fin_flags[load_slot] <= zero_burst;
      end else if (cmd.commit_tick && tick_done) begin
        fin_flags[best_idx] <= 1'b1;
      end
      if (cmd.capture) begin
        have <= 1'b0;
      end else if (cand_ready && cand_better) begin
        have <= 1'b1;
      end
      if (cmd.commit_load || cmd.commit_tick) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `PPS_ASSERT_IMPLIES(a_done_le_count, 1'b1, done_count <= task_count, "more tasks done than loaded")
  `PPS_ASSERT_IMPLIES(a_flags_match, 1'b1, $countones(fin_flags) == done_count, "finished flags disagree with the done count")
  `PPS_ASSERT_NEXT(a_clock_step, cmd.commit_tick, clock_now == $past(clock_now) + 32'd1, "clock did not advance on a tick")

endmodule

// File: rtl/preemptive_priority_scheduler_unit.sv
// Top level of the preemptive priority scheduler: controller and datapath.
//
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   pps_pkg::in_t
// rsp       out        rsp_valid/rsp_stall   pps_pkg::out_t
//
// A load request writes its result register from the load state that follows acceptance.
// A tick request writes its result register from the tick state, after the scan and the drain:
// the scan reads all 16 table slots one per cycle through the single read port of the
// task table, the drain state finishes the last compare and the tick state makes the update.
// Reset clears the clock, the counters, the finished flags and the result valid.
// A request is taken only while the block is idle; a held result stalls the commit.
module preemptive_priority_scheduler_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pps_pkg::in_t  req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pps_pkg::out_t rsp
);
  import pps_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .op        (req.operation),
    .status    (status),
    .req_stall (req_stall),
    .cmd       (cmd)
  );

  pps_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: tb/pps_schedule_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the priority scheduler: predicts every result from the accepted requests.
module pps_schedule_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  pps_pkg::in_t  req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  pps_pkg::out_t rsp,
  output int            mismatches,
  output int            outstanding,
  output int            tasks_finished,
  output int            idle_ticks,
  output int            loads_rejected
);
  import pps_pkg::*;

  logic [31:0]        sched_clock;
  int                 loaded;
  int                 completed;
  logic [15:0]        task_burst     [MAX_TASKS];
  logic [15:0]        task_left      [MAX_TASKS];
  logic [31:0]        task_arrival   [MAX_TASKS];
  logic signed [15:0] task_prio      [MAX_TASKS];
  logic [31:0]        task_first_run [MAX_TASKS];
  logic               task_done      [MAX_TASKS];
  out_t               expected_q[$];

  function automatic out_t next_schedule_result(in_t r);
    out_t o;
    int   pick;
    int   i;
    o = '0;
    o.tick_time = sched_clock;
    if (r.operation == OP_LOAD) begin
      if (loaded >= MAX_TASKS) begin
        o.table_full = 1'b1;
        loads_rejected++;
      end else begin
        task_burst[loaded]     = r.burst_length;
        task_left[loaded]      = r.burst_length;
        task_arrival[loaded]   = r.arrival;
        task_prio[loaded]      = r.task_priority;
        task_first_run[loaded] = '0;
        task_done[loaded]      = (r.burst_length == 16'd0);
        if (r.burst_length == 16'd0) completed++;
        o.task_slot = SLOT_W'(loaded);
        loaded++;
      end
    end else begin
      pick = -1;
      for (i = 0; i < loaded; i++) begin
        if (!task_done[i] && task_arrival[i] <= sched_clock) begin
          if (pick < 0 || task_prio[i] > task_prio[pick] ||
              (task_prio[i] == task_prio[pick] && task_arrival[i] < task_arrival[pick])) begin
            pick = i;
          end
        end
      end
      if (pick < 0) begin
        o.idle = 1'b1;
        idle_ticks++;
      end else begin
        o.task_slot = SLOT_W'(pick);
        if (task_left[pick] == task_burst[pick]) task_first_run[pick] = sched_clock;
        task_left[pick] = task_left[pick] - 16'd1;
        if (task_left[pick] == 16'd0) begin
          task_done[pick] = 1'b1;
          completed++;
          tasks_finished++;
          o.finished   = 1'b1;
          o.turnaround = sched_clock + 32'd1 - task_arrival[pick];
          o.waiting    = o.turnaround - {16'd0, task_burst[pick]};
          o.response   = task_first_run[pick] - task_arrival[pick];
        end
      end
      sched_clock = sched_clock + 32'd1;
    end
    o.all_done = (completed == loaded);
    return o;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  task automatic compare_result(out_t want, out_t got);
    check_field("tick_time", want.tick_time, got.tick_time);
    check_field("idle", want.idle, got.idle);
    check_field("task_slot", want.task_slot, got.task_slot);
    check_field("table_full", want.table_full, got.table_full);
    check_field("finished", want.finished, got.finished);
    check_field("turnaround", want.turnaround, got.turnaround);
    check_field("waiting", want.waiting, got.waiting);
    check_field("response", want.response, got.response);
    check_field("all_done", want.all_done, got.all_done);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sched_clock = '0;
      loaded      = 0;
      completed   = 0;
      for (int k = 0; k < MAX_TASKS; k++) task_done[k] = 1'b0;
      expected_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected no result, actual %p", $time, rsp);
        end else begin
          compare_result(expected_q.pop_front(), rsp);
        end
      end
      if (req_valid && !req_stall) expected_q.push_back(next_schedule_result(req));
    end
    outstanding <= expected_q.size();
  end

endmodule

// File: tb/preemptive_priority_scheduler_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the priority scheduler: request stimulus, result flow control and verdict.
module preemptive_priority_scheduler_unit_tb;
  import pps_pkg::*;

  localparam int RANDOM_REQUESTS  = 1580;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int DRAIN_CYCLES     = 40;
  localparam int LONG_HOLD_CYCLES = 300;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  in_t  req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  out_t rsp;

  int mismatches;
  int outstanding;
  int tasks_finished;
  int idle_ticks;
  int loads_rejected;
  int loads_sent      = 0;
  int ticks_sent      = 0;
  int responses_taken = 0;
  int cycle_count     = 0;
  bit sender_calm     = 1'b0;
  bit receiver_calm   = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  preemptive_priority_scheduler_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  pps_schedule_checker u_schedule_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp            (rsp),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .tasks_finished (tasks_finished),
    .idle_ticks     (idle_ticks),
    .loads_rejected (loads_rejected)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at cycle limit %0d with %0d results pending", cycle_count,
               outstanding);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic in_t load_item(logic [15:0] burst, logic [31:0] arrive,
                                    logic signed [15:0] prio);
    in_t r;
    r.operation     = OP_LOAD;
    r.burst_length  = burst;
    r.arrival       = arrive;
    r.task_priority = prio;
    return r;
  endfunction

  function automatic in_t tick_item();
    in_t r;
    r.operation     = OP_TICK;
    r.burst_length  = 16'($urandom);
    r.arrival       = $urandom;
    r.task_priority = 16'($urandom);
    return r;
  endfunction

  function automatic in_t random_request();
    in_t r;
    int  roll;
    roll = $urandom_range(0, 99);
    if ((loads_sent < MAX_TASKS) ? (roll < 2) : (roll < 5)) begin
      if ($urandom_range(0, 3) != 0)
        r = load_item(16'($urandom_range(1, 40)),
                      32'(ticks_sent + $urandom_range(0, 45)) - 32'd5,
                      16'(int'($urandom_range(0, 6)) - 3));
      else
        r = load_item(16'($urandom), $urandom, 16'($urandom));
    end else begin
      r = tick_item();
    end
    return r;
  endfunction

  task automatic send_request(in_t r);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    if (r.operation == OP_LOAD) loads_sent++;
    else ticks_sent++;
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : result_sink
    int hold;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (responses_taken == 300 || responses_taken == 1100) hold = LONG_HOLD_CYCLES;
      else hold = receiver_calm ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (rsp_valid !== 1'b1);
      responses_taken++;
      if (responses_taken % 89 == 0) receiver_calm = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin : request_source
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty table, a zero-length task, then one task that finishes on its first run.
    send_request(tick_item());
    send_request(load_item(16'd0, 32'd0, 16'sd0));
    send_request(tick_item());
    send_request(load_item(16'd1, 32'd0, 16'sd5));
    send_request(tick_item());
    // Equal priorities split by arrival and by slot, a preempting top priority,
    // a task that never becomes ready and one that only runs when nothing else can.
    send_request(load_item(16'd3, 32'd5, 16'sd100));
    send_request(load_item(16'd2, 32'd5, 16'sd100));
    send_request(load_item(16'd2, 32'd4, 16'sd100));
    send_request(load_item(16'd4, 32'd6, 16'sh7FFF));
    send_request(load_item(16'hFFFF, 32'hFFFF_FFFF, -16'sd1));
    send_request(load_item(16'd2, 32'd0, -16'sd32768));
    repeat (11) send_request(tick_item());
    wait_for_results();

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      send_request(random_request());
      if (n % 97 == 96) sender_calm = ($urandom_range(0, 2) == 0);
      if (n % 400 == 399) wait_for_results();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests: %0d loads and %0d ticks.", loads_sent + ticks_sent,
             loads_sent, ticks_sent);
    $display("Scheduler completed %0d tasks, idled on %0d ticks, turned away %0d loads.",
             tasks_finished, idle_ticks, loads_rejected);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
